@@ rtl/cbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier split and slope block.
package cbs_pkg;

   // Slope grows by three bits: one for the difference, two for the factor of three.
   localparam int unsigned SLOPE_EXTRA_BITS = 3;

   // Register stages from input beat to output register.
   localparam int unsigned STAGES = 9;

   // Per-stage load enables of one lerp unit: difference, product, sum.
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_c;
   } cbs_adv_type;

endpackage

@@ rtl/cbs_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: four control point coordinates and the split parameter.
interface cbs_req_if import cbs_pkg::*; #(
   parameter int COORD_WIDTH     = 32,
   parameter int PARAM_FRAC_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] ctrl_a;
   logic signed [COORD_WIDTH-1:0] ctrl_b;
   logic signed [COORD_WIDTH-1:0] ctrl_c;
   logic signed [COORD_WIDTH-1:0] ctrl_d;
   logic [PARAM_FRAC_BITS:0]      split_param;

   modport source (output valid, ctrl_a, ctrl_b, ctrl_c, ctrl_d, split_param, input ready);
   modport sink   (input valid, ctrl_a, ctrl_b, ctrl_c, ctrl_d, split_param, output ready);
endinterface

@@ rtl/cbs_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: both halves of the split curve and the slope at the split.
interface cbs_rsp_if import cbs_pkg::*; #(
   parameter int COORD_WIDTH = 32
);
   logic                                           valid;
   logic                                           ready;
   logic signed [COORD_WIDTH-1:0]                  left_first;
   logic signed [COORD_WIDTH-1:0]                  left_second;
   logic signed [COORD_WIDTH-1:0]                  left_third;
   logic signed [COORD_WIDTH-1:0]                  split_point;
   logic signed [COORD_WIDTH-1:0]                  right_second;
   logic signed [COORD_WIDTH-1:0]                  right_third;
   logic signed [COORD_WIDTH-1:0]                  right_last;
   logic signed [COORD_WIDTH+SLOPE_EXTRA_BITS-1:0] slope;

   modport source (output valid, left_first, left_second, left_third, split_point,
                   right_second, right_third, right_last, slope, input ready);
   modport sink   (input valid, left_first, left_second, left_third, split_point,
                   right_second, right_third, right_last, slope, output ready);
endinterface

@@ rtl/cbs_lerp.sv @@
`timescale 1ns / 1ps
// Three-stage lerp unit: difference, product with t, floor-shifted sum.
module cbs_lerp import cbs_pkg::*; #(
   parameter int COORD_WIDTH     = 32,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  cbs_adv_type                   adv,
   input  logic signed [COORD_WIDTH-1:0] lhs,
   input  logic signed [COORD_WIDTH-1:0] rhs,
   input  logic [PARAM_FRAC_BITS:0]      param,
   output logic signed [COORD_WIDTH:0]   diff,
   output logic signed [COORD_WIDTH-1:0] result,
   output logic [PARAM_FRAC_BITS:0]      param_out
);
   localparam int PROD_WIDTH = COORD_WIDTH + PARAM_FRAC_BITS + 3;

   logic signed [COORD_WIDTH-1:0] base_a_ff;
   logic signed [COORD_WIDTH:0]   diff_ff;
   logic [PARAM_FRAC_BITS:0]      param_a_ff;
   logic signed [COORD_WIDTH-1:0] base_b_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic [PARAM_FRAC_BITS:0]      param_b_ff;
   logic signed [COORD_WIDTH-1:0] result_ff;
   logic [PARAM_FRAC_BITS:0]      param_c_ff;

   logic signed [COORD_WIDTH:0]   diff_in;
   logic signed [PROD_WIDTH-1:0]  prod_in;
   logic signed [PROD_WIDTH-1:0]  prod_shift;
   logic signed [COORD_WIDTH:0]   sum_wide;
   logic signed [COORD_WIDTH-1:0] result_in;

   assign diff_in    = {rhs[COORD_WIDTH-1], rhs} - {lhs[COORD_WIDTH-1], lhs};
   assign prod_in    = diff_ff * $signed({1'b0, param_a_ff});
   // floor division by one: arithmetic shift of the signed product
   assign prod_shift = prod_ff >>> PARAM_FRAC_BITS;
   assign sum_wide   = {base_b_ff[COORD_WIDTH-1], base_b_ff} + prod_shift[COORD_WIDTH:0];
   // the lerp stays between its operands, so the top bit carries nothing
   assign result_in  = sum_wide[COORD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (adv.load_a) begin
         base_a_ff  <= lhs;
         diff_ff    <= diff_in;
         param_a_ff <= param;
      end
      if (adv.load_b) begin
         base_b_ff  <= base_a_ff;
         prod_ff    <= prod_in;
         param_b_ff <= param_a_ff;
      end
      if (adv.load_c) begin
         result_ff  <= result_in;
         param_c_ff <= param_b_ff;
      end
   end

   assign diff      = diff_ff;
   assign result    = result_ff;
   assign param_out = param_c_ff;
endmodule

@@ rtl/cubic_bezier_split_and_slope.sv @@
`timescale 1ns / 1ps
// Splits one axis of a cubic Bezier curve at t by de Casteljau and returns both halves
// and the slope at t. The block takes one beat per clock while no stall backs up to the
// first stage; a beat passes three levels of lerp units, each a difference, a multiply
// and a sum stage, with the last sum as output register.
// Six multipliers of (COORD_WIDTH+1) by (PARAM_FRAC_BITS+2) bits do the work. A stall
// on the response side holds only the full stages after the last empty one; the rest
// move on. Values of t above one are taken as one. Reset clears only the stage valid bits.
module cubic_bezier_split_and_slope import cbs_pkg::*; #(
   parameter int COORD_WIDTH     = 32,
   parameter int PARAM_FRAC_BITS = 16
) (
   input logic    clock,
   input logic    reset,
   cbs_req_if.sink   req_chan,
   cbs_rsp_if.source rsp_chan
);
   localparam int SLOPE_WIDTH = COORD_WIDTH + SLOPE_EXTRA_BITS;
   localparam logic [PARAM_FRAC_BITS:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   ready_stage;

   logic [PARAM_FRAC_BITS:0] t_sat;

   logic signed [COORD_WIDTH-1:0] a_pipe_ff [0:STAGES-1];
   logic signed [COORD_WIDTH-1:0] d_pipe_ff [0:STAGES-1];
   logic signed [COORD_WIDTH-1:0] ab_ff     [3:STAGES-1];
   logic signed [COORD_WIDTH-1:0] cd_ff     [3:STAGES-1];
   logic signed [COORD_WIDTH-1:0] abc_ff    [6:STAGES-1];
   logic signed [COORD_WIDTH-1:0] bcd_ff    [6:STAGES-1];
   logic signed [SLOPE_WIDTH-1:0] slope_ff  [7:STAGES-1];
   logic signed [SLOPE_WIDTH-1:0] slope_in;

   cbs_adv_type adv_lvl1, adv_lvl2, adv_lvl3;

   logic signed [COORD_WIDTH-1:0] ab_res, bc_res, cd_res, abc_res, bcd_res, mid_res;
   logic [PARAM_FRAC_BITS:0]      ab_param, abc_param;
   logic signed [COORD_WIDTH:0]   mid_diff;

   // A stage takes a new beat when it is empty or its beat moves on.
   always_comb begin
      ready_stage[STAGES] = rsp_chan.ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         ready_stage[k] = !v_ff[k] || ready_stage[k+1];
      end
   end

   assign req_chan.ready = ready_stage[0];

   assign t_sat = (req_chan.split_param > PARAM_ONE) ? PARAM_ONE : req_chan.split_param;

   assign adv_lvl1 = '{load_a: ready_stage[0], load_b: ready_stage[1], load_c: ready_stage[2]};
   assign adv_lvl2 = '{load_a: ready_stage[3], load_b: ready_stage[4], load_c: ready_stage[5]};
   assign adv_lvl3 = '{load_a: ready_stage[6], load_b: ready_stage[7], load_c: ready_stage[8]};

   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_ab (
      .clock(clock), .adv(adv_lvl1), .lhs(req_chan.ctrl_a), .rhs(req_chan.ctrl_b),
      .param(t_sat), .diff(), .result(ab_res), .param_out(ab_param));
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_bc (
      .clock(clock), .adv(adv_lvl1), .lhs(req_chan.ctrl_b), .rhs(req_chan.ctrl_c),
      .param(t_sat), .diff(), .result(bc_res), .param_out());
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_cd (
      .clock(clock), .adv(adv_lvl1), .lhs(req_chan.ctrl_c), .rhs(req_chan.ctrl_d),
      .param(t_sat), .diff(), .result(cd_res), .param_out());

   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_abc (
      .clock(clock), .adv(adv_lvl2), .lhs(ab_res), .rhs(bc_res),
      .param(ab_param), .diff(), .result(abc_res), .param_out(abc_param));
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_bcd (
      .clock(clock), .adv(adv_lvl2), .lhs(bc_res), .rhs(cd_res),
      .param(ab_param), .diff(), .result(bcd_res), .param_out());

   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_mid (
      .clock(clock), .adv(adv_lvl3), .lhs(abc_res), .rhs(bcd_res),
      .param(abc_param), .diff(mid_diff), .result(mid_res), .param_out());

   // three times the level-two difference, as a shift and an add
   assign slope_in = {{2{mid_diff[COORD_WIDTH]}}, mid_diff}
                   + {mid_diff[COORD_WIDTH], mid_diff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ready_stage[0]) begin
            v_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (ready_stage[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_stage[0]) begin
         a_pipe_ff[0] <= req_chan.ctrl_a;
         d_pipe_ff[0] <= req_chan.ctrl_d;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ready_stage[k]) begin
            a_pipe_ff[k] <= a_pipe_ff[k-1];
            d_pipe_ff[k] <= d_pipe_ff[k-1];
         end
      end
      if (ready_stage[3]) begin
         ab_ff[3] <= ab_res;
         cd_ff[3] <= cd_res;
      end
      for (int k = 4; k < STAGES; k++) begin
         if (ready_stage[k]) begin
            ab_ff[k] <= ab_ff[k-1];
            cd_ff[k] <= cd_ff[k-1];
         end
      end
      if (ready_stage[6]) begin
         abc_ff[6] <= abc_res;
         bcd_ff[6] <= bcd_res;
      end
      for (int k = 7; k < STAGES; k++) begin
         if (ready_stage[k]) begin
            abc_ff[k] <= abc_ff[k-1];
            bcd_ff[k] <= bcd_ff[k-1];
         end
      end
      if (ready_stage[7]) begin
         slope_ff[7] <= slope_in;
      end
      if (ready_stage[8]) begin
         slope_ff[8] <= slope_ff[7];
      end
   end

   assign rsp_chan.valid        = v_ff[STAGES-1];
   assign rsp_chan.left_first   = a_pipe_ff[STAGES-1];
   assign rsp_chan.left_second  = ab_ff[STAGES-1];
   assign rsp_chan.left_third   = abc_ff[STAGES-1];
   assign rsp_chan.split_point  = mid_res;
   assign rsp_chan.right_second = bcd_ff[STAGES-1];
   assign rsp_chan.right_third  = cd_ff[STAGES-1];
   assign rsp_chan.right_last   = d_pipe_ff[STAGES-1];
   assign rsp_chan.slope        = slope_ff[STAGES-1];

`ifndef SYNTH
   logic signed [COORD_WIDTH:0]   chk_diff;
   logic signed [SLOPE_WIDTH-1:0] chk_slope;

   assign chk_diff  = {bcd_ff[STAGES-1][COORD_WIDTH-1], bcd_ff[STAGES-1]}
                    - {abc_ff[STAGES-1][COORD_WIDTH-1], abc_ff[STAGES-1]};
   assign chk_slope = {{2{chk_diff[COORD_WIDTH]}}, chk_diff}
                    + {chk_diff[COORD_WIDTH], chk_diff, 1'b0};

   // an accepted beat lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[0])
      else $error("accepted beat missing from first stage");

   // slope and level-two points leave together, so they must agree
   a_slope_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.slope == chk_slope)
      else $error("slope out of step with level-two points");

   // the curve point lies between its two level-two points
   a_point_between: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ((abc_ff[STAGES-1] <= mid_res && mid_res <= bcd_ff[STAGES-1]) ||
          (bcd_ff[STAGES-1] <= mid_res && mid_res <= abc_ff[STAGES-1])))
      else $error("split point outside its operands");

   // a full pipe held by the response side stays full
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_chan.ready |=> (&v_ff))
      else $error("full pipe lost a beat under stall");
`endif
endmodule

@@ tb/cubic_bezier_split_and_slope_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the cubic Bezier split: directed and random curves, predicted results.
module cubic_bezier_split_and_slope_tb;
   import cbs_pkg::*;

   localparam int CW           = 32;
   localparam int PFB          = 16;
   localparam int SW           = CW + SLOPE_EXTRA_BITS;
   localparam int T_ONE        = 1 << PFB;
   localparam int RANDOM_BEATS = 2000;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_AT      = 400;
   localparam int QUIET_FROM   = 1000;
   localparam int QUIET_TO     = 1300;
   localparam int DRAIN_AT     = 1500;
   localparam int LIMIT_CYCLES = 200000;

   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

   typedef struct {
      logic signed [CW-1:0] ctrl_a;
      logic signed [CW-1:0] ctrl_b;
      logic signed [CW-1:0] ctrl_c;
      logic signed [CW-1:0] ctrl_d;
      logic [PFB:0]         split_param;
   } curve_axis_type;

   typedef struct {
      logic signed [CW-1:0] left_first;
      logic signed [CW-1:0] left_second;
      logic signed [CW-1:0] left_third;
      logic signed [CW-1:0] split_point;
      logic signed [CW-1:0] right_second;
      logic signed [CW-1:0] right_third;
      logic signed [CW-1:0] right_last;
      logic signed [SW-1:0] slope;
   } split_axis_type;

   class curve_split_tracker;
      split_axis_type pending_splits[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      // floor((a*(one-t) + b*t) / one), taken as a + floor((b-a)*t / one)
      function longint lerp_q(longint lo, longint hi, longint t);
         return lo + (((hi - lo) * t) >>> PFB);
      endfunction

      function split_axis_type split_curve(curve_axis_type cv);
         longint         t, ab, bc, cd, abc, bcd;
         split_axis_type r;
         t = (cv.split_param > T_ONE) ? longint'(T_ONE) : longint'(cv.split_param);
         ab  = lerp_q(longint'(cv.ctrl_a), longint'(cv.ctrl_b), t);
         bc  = lerp_q(longint'(cv.ctrl_b), longint'(cv.ctrl_c), t);
         cd  = lerp_q(longint'(cv.ctrl_c), longint'(cv.ctrl_d), t);
         abc = lerp_q(ab, bc, t);
         bcd = lerp_q(bc, cd, t);
         r.left_first   = cv.ctrl_a;
         r.left_second  = ab[CW-1:0];
         r.left_third   = abc[CW-1:0];
         r.split_point  = CW'(lerp_q(abc, bcd, t));
         r.right_second = bcd[CW-1:0];
         r.right_third  = cd[CW-1:0];
         r.right_last   = cv.ctrl_d;
         r.slope        = SW'((bcd - abc) * 3);
         return r;
      endfunction

      function void note_curve(curve_axis_type cv);
         pending_splits.insert(pending_splits.size(), split_curve(cv));
      endfunction

      function int pending();
         return pending_splits.size();
      endfunction

      function void check_field(string name, longint want, longint got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_split(split_axis_type got);
         split_axis_type want;
         if (pending_splits.size() == 0) begin
            $error("result beat with no curve outstanding");
            errors++;
            return;
         end
         want = pending_splits.pop_front();
         check_field("left_first", want.left_first, got.left_first);
         check_field("left_second", want.left_second, got.left_second);
         check_field("left_third", want.left_third, got.left_third);
         check_field("split_point", want.split_point, got.split_point);
         check_field("right_second", want.right_second, got.right_second);
         check_field("right_third", want.right_third, got.right_third);
         check_field("right_last", want.right_last, got.right_last);
         check_field("slope", want.slope, got.slope);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   req_beats = 0;
   int   cycle_count;
   bit   held_once;

   curve_split_tracker tracker = new();

   cbs_req_if #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PFB)) req_chan();
   cbs_rsp_if #(.COORD_WIDTH(CW)) rsp_chan();

   cubic_bezier_split_and_slope #(
      .COORD_WIDTH(CW),
      .PARAM_FRAC_BITS(PFB)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit quiet_window();
      return req_beats >= QUIET_FROM && req_beats < QUIET_TO;
   endfunction

   function automatic curve_axis_type make_curve(logic signed [CW-1:0] a,
                                                 logic signed [CW-1:0] b,
                                                 logic signed [CW-1:0] c,
                                                 logic signed [CW-1:0] d,
                                                 int t);
      curve_axis_type cv;
      cv.ctrl_a      = a;
      cv.ctrl_b      = b;
      cv.ctrl_c      = c;
      cv.ctrl_d      = d;
      cv.split_param = t[PFB:0];
      return cv;
   endfunction

   function automatic curve_axis_type random_curve();
      curve_axis_type       cv;
      logic signed [CW-1:0] pts [4];
      int                   style;
      style = $urandom_range(0, 9);
      for (int k = 0; k < 4; k++) begin
         case (style) inside
            [0:4]: pts[k] = $urandom;
            [5:6]: pts[k] = $urandom_range(0, 1 << 21) - (1 << 20);
            7: begin
               case ($urandom_range(0, 4))
                  0: pts[k] = COORD_MIN;
                  1: pts[k] = COORD_MAX;
                  2: pts[k] = '0;
                  3: pts[k] = -1;
                  default: pts[k] = 1;
               endcase
            end
            default: begin
               // smooth curve: each point a small step from the last
               if (k == 0) pts[k] = $urandom;
               else pts[k] = pts[k-1] + ($urandom_range(0, 1 << 18) - (1 << 17));
            end
         endcase
      end
      cv.ctrl_a = pts[0];
      cv.ctrl_b = pts[1];
      cv.ctrl_c = pts[2];
      cv.ctrl_d = pts[3];
      case ($urandom_range(0, 9))
         7: begin
            case ($urandom_range(0, 3))
               0: cv.split_param = '0;
               1: cv.split_param = (PFB+1)'(T_ONE);
               2: cv.split_param = (PFB+1)'(1);
               default: cv.split_param = (PFB+1)'(T_ONE - 1);
            endcase
         end
         8: cv.split_param = (PFB+1)'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
         default: cv.split_param = (PFB+1)'($urandom_range(0, T_ONE));
      endcase
      return cv;
   endfunction

   task automatic offer_curve(curve_axis_type cv);
      req_chan.valid       <= 1'b1;
      req_chan.ctrl_a      <= cv.ctrl_a;
      req_chan.ctrl_b      <= cv.ctrl_b;
      req_chan.ctrl_c      <= cv.ctrl_c;
      req_chan.ctrl_d      <= cv.ctrl_d;
      req_chan.split_param <= cv.split_param;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_splits();
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   always @(posedge clock) begin
      split_axis_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            tracker.note_curve(make_curve(req_chan.ctrl_a, req_chan.ctrl_b, req_chan.ctrl_c,
                                          req_chan.ctrl_d, int'(req_chan.split_param)));
            req_beats <= req_beats + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.left_first   = rsp_chan.left_first;
            got.left_second  = rsp_chan.left_second;
            got.left_third   = rsp_chan.left_third;
            got.split_point  = rsp_chan.split_point;
            got.right_second = rsp_chan.right_second;
            got.right_third  = rsp_chan.right_third;
            got.right_last   = rsp_chan.right_last;
            got.slope        = rsp_chan.slope;
            tracker.check_split(got);
         end
      end
   end

   // Receiver: random stalls, one long hold-off to back the pipeline up, a quiet stretch.
   initial begin
      held_once = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && req_beats >= HOLD_AT) begin
            held_once = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet_window()) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= 23);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      curve_axis_type directed[$];
      curve_axis_type cv;
      int             total;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.ctrl_a      <= '0;
      req_chan.ctrl_b      <= '0;
      req_chan.ctrl_c      <= '0;
      req_chan.ctrl_d      <= '0;
      req_chan.split_param <= '0;

      // ends of the curve, extremes of coordinates, parameter above one, rounding of negatives
      directed.insert(directed.size(), make_curve('0, '0, '0, '0, 0));
      directed.insert(directed.size(), make_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0));
      directed.insert(directed.size(),
                      make_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, T_ONE));
      directed.insert(directed.size(),
                      make_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, T_ONE / 2));
      directed.insert(directed.size(),
                      make_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, T_ONE / 2));
      directed.insert(directed.size(),
                      make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, T_ONE - 1));
      directed.insert(directed.size(), make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1));
      directed.insert(directed.size(),
                      make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, T_ONE - 1));
      directed.insert(directed.size(), make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1));
      directed.insert(directed.size(),
                      make_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, T_ONE + 1));
      directed.insert(directed.size(),
                      make_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 2 * T_ONE - 1));
      directed.insert(directed.size(),
                      make_curve(32'sh0001_8000, -32'sh0003_0000, 32'sh7FFF_0000,
                                 -32'sh1234_5678, T_ONE + 32'h5555));
      directed.insert(directed.size(), make_curve(-1, 1, -1, 1, T_ONE / 3));
      directed.insert(directed.size(), make_curve(1, -1, 1, -1, 3));
      directed.insert(directed.size(),
                      make_curve(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                 32'sh0004_0000, T_ONE / 4));
      directed.insert(directed.size(), make_curve(COORD_MIN, '0, '0, COORD_MAX, 32'h8000));
      directed.insert(directed.size(),
                      make_curve(-32'sh0000_0007, 32'sh0000_0005, -32'sh0000_0003,
                                 32'sh0000_0002, 32'hAAAA));
      directed.insert(directed.size(),
                      make_curve(32'sh5555_5555, -32'sh2AAA_AAAB, 32'sh0F0F_0F0F,
                                 -32'sh7070_7070, 32'h0001));
      directed.insert(directed.size(),
                      make_curve(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, T_ONE / 2));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      total = directed.size() + RANDOM_BEATS;
      for (int i = 0; i < total; i++) begin
         if (i < directed.size()) cv = directed[i];
         else cv = random_curve();
         if (i == DRAIN_AT) begin
            // hold the sender until every outstanding result is back
            req_chan.valid <= 1'b0;
            drain_splits();
         end
         offer_curve(cv);
         if (!(i >= QUIET_FROM && i < QUIET_TO)) begin
            while ($urandom_range(0, 99) < 23) begin
               req_chan.valid <= 1'b0;
               @(posedge clock);
            end
         end
      end
      req_chan.valid <= 1'b0;
      drain_splits();
      repeat (STAGES + 4) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/cbs_pkg.sv
rtl/cbs_req_if.sv
rtl/cbs_rsp_if.sv
rtl/cbs_lerp.sv
rtl/cubic_bezier_split_and_slope.sv
tb/cubic_bezier_split_and_slope_tb.sv
